FILE: sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Shared item types, character codes, status codes and stack cell commands.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Default number of entries on the operand stack.
  localparam int StackDepthDefault = 16;

  // Width of a stack entry and of every arithmetic operand.
  localparam int WordWidth = 32;

  // Character codes recognised by the evaluator.
  localparam logic [7:0] SymZero  = 8'h30;  // '0'
  localparam logic [7:0] SymNine  = 8'h39;  // '9'
  localparam logic [7:0] SymPlus  = 8'h2B;  // '+'
  localparam logic [7:0] SymMinus = 8'h2D;  // '-'
  localparam logic [7:0] SymTimes = 8'h2A;  // '*'
  localparam logic [7:0] SymSlash = 8'h2F;  // '/'

  // Sticky status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusUnderflow = 2'd1;
  localparam logic [1:0] StatusDivZero   = 2'd2;
  localparam logic [1:0] StatusFull      = 2'd3;

  // What a stack cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_UPPER = 2'd1,
    CELL_TAKE_LOWER = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_item_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] top_value;
    logic        [4:0]           stack_depth;
    logic        [1:0]           status;
  } res_item_t;

endpackage

FILE: sv/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Flow: a digit, add, subtract, multiply, error or ignored character passes
// from IDLE to REPORT and then into the output register; a divide waits in DIV
// for the bit-serial divider, which produces one quotient bit per cycle.
// One item is in work at a time; a new item is taken only back in IDLE.
// Reset clears the depth count, the sticky status and all handshake state.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int StackDepth = pse_pkg::StackDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sym_valid,
  output logic               sym_stall,
  input  pse_pkg::sym_item_t sym_item,
  output logic               res_valid,
  input  logic               res_stall,
  output pse_pkg::res_item_t res_item
);

  localparam int W  = pse_pkg::WordWidth;
  // The depth counter must be able to hold the full stack depth itself.
  localparam int DW = $clog2(StackDepth + 1);

  // Control sequence for one item: it is taken in IDLE, waits in DIV while
  // the divider runs, and hands its result to the output register in REPORT.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIV    = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic [1:0]    status;
  logic [1:0]    status_next;
  logic          last_q;

  // The operand stack is a row of cells; cell 0 is the top of the stack and
  // cell 1 the entry beneath it. A push moves every entry one cell down, a
  // combining operator puts its result in cell 0 and moves the rest up.
  logic [W-1:0]       vals [StackDepth];
  pse_pkg::cell_cmd_t cmd_top;
  pse_pkg::cell_cmd_t cmd_rest;
  logic [W-1:0]       new_top;

  logic          accept;
  logic          is_digit;
  logic          is_op;
  logic          stack_full;
  logic          stack_short;
  logic [W-1:0]  left;
  logic [W-1:0]  right;
  logic [W-1:0]  alu_result;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quotient;
  logic          res_free;

  assign accept    = sym_valid && !sym_stall;
  // One item is in work at a time; the output register still lets a new
  // item in while the previous result waits to be taken.
  assign sym_stall = (state != S_IDLE);
  assign res_free  = !res_valid || !res_stall;

  assign is_digit    = (sym_item.symbol >= pse_pkg::SymZero) &&
                       (sym_item.symbol <= pse_pkg::SymNine);
  assign is_op       = (sym_item.symbol == pse_pkg::SymPlus)  ||
                       (sym_item.symbol == pse_pkg::SymMinus) ||
                       (sym_item.symbol == pse_pkg::SymTimes) ||
                       (sym_item.symbol == pse_pkg::SymSlash);
  assign stack_full  = (depth == DW'(StackDepth));
  assign stack_short = (depth < DW'(2));

  // The deeper entry is the left operand, the top entry the right one.
  assign left  = vals[1];
  assign right = vals[0];

  always_comb begin
    case (sym_item.symbol)
      pse_pkg::SymPlus:  alu_result = left + right;
      pse_pkg::SymMinus: alu_result = left - right;
      default:           alu_result = left * right;
    endcase
  end

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .left     (left),
    .right    (right),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Next-state and stack control. An error leaves the stack as it is and
  // raises the status only if no earlier error of this expression holds it.
  always_comb begin
    state_next  = state;
    depth_next  = depth;
    status_next = status;
    cmd_top     = pse_pkg::CELL_HOLD;
    cmd_rest    = pse_pkg::CELL_HOLD;
    new_top     = alu_result;
    div_start   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_REPORT;
          if (is_digit) begin
            if (stack_full) begin
              if (status == pse_pkg::StatusOk) begin
                status_next = pse_pkg::StatusFull;
              end
            end else begin
              new_top    = W'(sym_item.symbol - pse_pkg::SymZero);
              cmd_top    = pse_pkg::CELL_TAKE_UPPER;
              cmd_rest   = pse_pkg::CELL_TAKE_UPPER;
              depth_next = depth + DW'(1);
            end
          end else if (is_op) begin
            if (stack_short) begin
              if (status == pse_pkg::StatusOk) begin
                status_next = pse_pkg::StatusUnderflow;
              end
            end else if (sym_item.symbol == pse_pkg::SymSlash) begin
              if (right == '0) begin
                if (status == pse_pkg::StatusOk) begin
                  status_next = pse_pkg::StatusDivZero;
                end
              end else begin
                div_start  = 1'b1;
                state_next = S_DIV;
              end
            end else begin
              cmd_top    = pse_pkg::CELL_TAKE_UPPER;
              cmd_rest   = pse_pkg::CELL_TAKE_LOWER;
              depth_next = depth - DW'(1);
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          new_top    = div_quotient;
          cmd_top    = pse_pkg::CELL_TAKE_UPPER;
          cmd_rest   = pse_pkg::CELL_TAKE_LOWER;
          depth_next = depth - DW'(1);
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (res_free) begin
          state_next = S_IDLE;
          // The last item of an expression reports first, then clears.
          if (last_q) begin
            depth_next  = '0;
            status_next = pse_pkg::StatusOk;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < StackDepth; gi++) begin : g_cell
      logic [W-1:0]       upper;
      logic [W-1:0]       lower;
      pse_pkg::cell_cmd_t cmd;

      if (gi == 0) begin : g_top
        assign upper = new_top;
        assign cmd   = cmd_top;
      end else begin : g_inner
        assign upper = vals[gi-1];
        assign cmd   = cmd_rest;
      end

      if (gi == StackDepth - 1) begin : g_bottom
        assign lower = '0;
      end else begin : g_above
        assign lower = vals[gi+1];
      end

      pse_cell u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .upper (upper),
        .lower (lower),
        .value (vals[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      depth  <= '0;
      status <= pse_pkg::StatusOk;
    end else begin
      state  <= state_next;
      depth  <= depth_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= sym_item.last;
    end
  end

  // Output register. The reported depth is the count taken modulo 32, and an
  // empty stack reports a top value of zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_REPORT) && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_REPORT) && res_free) begin
      res_item.top_value   <= (depth == '0) ? '0 : vals[0];
      res_item.stack_depth <= 5'(depth);
      res_item.status      <= status;
    end
  end

endmodule

FILE: sv/pse_cell.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator cell
// One entry of the shifting operand stack. It holds its value, takes the value
// of the cell above on a push, or that of the cell below on a pop.
// ----------------------------------------------------------------------------
module pse_cell (
  input  logic                              clk,
  input  pse_pkg::cell_cmd_t                cmd,
  input  logic [pse_pkg::WordWidth-1:0]     upper,
  input  logic [pse_pkg::WordWidth-1:0]     lower,
  output logic [pse_pkg::WordWidth-1:0]     value
);

  always_ff @(posedge clk) begin
    case (cmd)
      pse_pkg::CELL_TAKE_UPPER: value <= upper;
      pse_pkg::CELL_TAKE_LOWER: value <= lower;
      default:                  value <= value;
    endcase
  end

endmodule

FILE: sv/pse_div.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator divider
// Signed 32-bit divide truncating toward zero, one quotient bit per cycle on
// the magnitudes with a sign correction at the end.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pse_pkg::WordWidth-1:0]     left,
  input  logic [pse_pkg::WordWidth-1:0]     right,
  output logic                              done,
  output logic [pse_pkg::WordWidth-1:0]     quotient
);

  localparam int W  = pse_pkg::WordWidth;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  dividend;
  logic [W-1:0]  divisor;
  logic [W-1:0]  remainder;
  logic          negate;

  logic [W+1:0]  trial;
  logic          borrow;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial  = {1'b0, remainder, dividend[W-1]} - {2'b00, divisor};
  assign borrow = trial[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(W);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend  <= left[W-1]  ? (~left + W'(1))  : left;
      divisor   <= right[W-1] ? (~right + W'(1)) : right;
      remainder <= '0;
      negate    <= left[W-1] ^ right[W-1];
    end else if (busy && (count != '0)) begin
      remainder <= borrow ? {remainder[W-2:0], dividend[W-1]} : trial[W-1:0];
      dividend  <= {dividend[W-2:0], ~borrow};
    end
  end

  assign done     = busy && (count == '0);
  assign quotient = negate ? (~dividend + W'(1)) : dividend;

endmodule
